// File: rtl/core/cals_pkg.sv
`default_nettype none

package cals_pkg;

  // result kinds carried on the result channel tuser
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  // quote currently open
  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] CountMax    = 8'hff;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] arg_number;
    logic       last;
  } res_t;

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h6e:   r = 8'h0a; // n
      8'h74:   r = 8'h09; // t
      8'h62:   r = 8'h08; // b
      8'h76:   r = 8'h0b; // v
      8'h61:   r = 8'h07; // a
      8'h72:   r = 8'h0d; // r
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/command_line_arg_splitter_top.sv
// command line argument splitter
// input channel (s_axis): one command line character per beat in tdata; a beat with
//   tlast high closes the line (its tdata is ignored) and resets the parser.
// result channel (m_axis): tuser is the result kind (argument byte, argument end,
//   line accepted, line rejected for an unterminated quote), tdata carries the
//   mapped byte in [7:0] and the argument index or count in [15:8], and tlast marks
//   the final result beat caused by one input beat.
// each input beat yields zero, one or two result beats; only a line close with an
//   argument still open yields two (argument end, then accepted).
// a character is parsed in the cycle it is accepted and its results are written
//   into a four-entry result queue, from which they are driven out in order.
// throughput: one input beat per cycle; tready stays high while the queue holds at
//   most two results, so the queue drain of one result per cycle is the limit.
// stall: while the receiver holds tready low the queue fills and input tready
//   drops once fewer than two slots remain; no result is lost or repeated.
// reset: rst_ni clears the parser (no quote, no argument, no escape, count zero)
//   and empties the result queue.
`default_nettype none

module command_line_arg_splitter_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire         s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] arg_number
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  // parser state
  cals_pkg::quote_e quote_q, quote_d;
  logic             in_arg_q, in_arg_d;
  logic             esc_q, esc_d;
  logic [7:0]       count_q, count_d;

  // result queue
  cals_pkg::res_t                    fifo_q [cals_pkg::FifoDepth];
  logic [cals_pkg::PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [cals_pkg::CntW-1:0]         fill_q;

  logic           in_beat, out_beat;
  logic [1:0]     n_res;
  cals_pkg::res_t res0, res1;
  logic [7:0]     ch;
  logic [7:0]     count_inc;
  cals_pkg::quote_e quote_ch;

  assign s_axis_tready = (fill_q <= cals_pkg::CntW'(cals_pkg::FifoDepth - 2));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != '0);
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign ch            = s_axis_tdata;
  assign count_inc     = (count_q == cals_pkg::CountMax) ? count_q : count_q + 8'd1;
  assign quote_ch      = (ch == cals_pkg::ChDquote) ? cals_pkg::QUOTE_DOUBLE
                                                    : cals_pkg::QUOTE_SINGLE;

  // per-character parse step
  always_comb begin
    quote_d  = quote_q;
    in_arg_d = in_arg_q;
    esc_d    = esc_q;
    count_d  = count_q;
    n_res    = 2'd0;
    res0     = '{kind: cals_pkg::KIND_BYTE, out_byte: 8'd0, arg_number: count_q, last: 1'b0};
    res1     = '{kind: cals_pkg::KIND_ACCEPT, out_byte: 8'd0, arg_number: count_q, last: 1'b1};
    if (s_axis_tlast) begin
      // line close: status, then parser back to its reset state
      if (quote_q != cals_pkg::QUOTE_NONE) begin
        res0.kind = cals_pkg::KIND_REJECT;
        n_res     = 2'd1;
      end else if (in_arg_q) begin
        res0.kind       = cals_pkg::KIND_END;
        res1.arg_number = count_inc;
        n_res           = 2'd2;
      end else begin
        res0.kind = cals_pkg::KIND_ACCEPT;
        n_res     = 2'd1;
      end
      quote_d  = cals_pkg::QUOTE_NONE;
      in_arg_d = 1'b0;
      esc_d    = 1'b0;
      count_d  = 8'd0;
    end else if (esc_q) begin
      esc_d         = 1'b0;
      in_arg_d      = 1'b1;
      res0.out_byte = cals_pkg::unescape(ch);
      n_res         = 2'd1;
    end else if (cals_pkg::is_blank(ch)) begin
      if (quote_q != cals_pkg::QUOTE_NONE) begin
        res0.out_byte = ch;
        n_res         = 2'd1;
      end else if (in_arg_q) begin
        res0.kind = cals_pkg::KIND_END;
        n_res     = 2'd1;
        count_d   = count_inc;
        in_arg_d  = 1'b0;
      end
    end else if ((ch == cals_pkg::ChDquote) || (ch == cals_pkg::ChSquote)) begin
      // empty quote pair still opens an argument
      in_arg_d = 1'b1;
      if (quote_q == cals_pkg::QUOTE_NONE) begin
        quote_d = quote_ch;
      end else if (quote_q == quote_ch) begin
        quote_d = cals_pkg::QUOTE_NONE;
      end else begin
        res0.out_byte = ch;
        n_res         = 2'd1;
      end
    end else if (ch == cals_pkg::ChBackslash) begin
      esc_d = 1'b1;
    end else begin
      in_arg_d      = 1'b1;
      res0.out_byte = ch;
      n_res         = 2'd1;
    end
    res0.last = (n_res == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q  <= cals_pkg::QUOTE_NONE;
      in_arg_q <= 1'b0;
      esc_q    <= 1'b0;
      count_q  <= 8'd0;
    end else if (in_beat) begin
      quote_q  <= quote_d;
      in_arg_q <= in_arg_d;
      esc_q    <= esc_d;
      count_q  <= count_d;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat && (n_res != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_beat && (n_res == 2'd2)) begin
      fifo_q[wr_ptr_q + cals_pkg::PtrW'(1)] <= res1;
    end
  end

  logic [cals_pkg::CntW-1:0] push_n;
  assign push_n = in_beat ? cals_pkg::CntW'(n_res) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[cals_pkg::PtrW-1:0];
      if (out_beat) begin
        rd_ptr_q <= rd_ptr_q + cals_pkg::PtrW'(1);
      end
      fill_q <= fill_q + push_n - cals_pkg::CntW'(out_beat);
    end
  end

  cals_pkg::res_t head;
  assign head         = fifo_q[rd_ptr_q];
  assign m_axis_tuser = head.kind;
  assign m_axis_tdata = {head.arg_number, head.out_byte};
  assign m_axis_tlast = head.last;

  // queue never overfills
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cals_pkg::CntW'(cals_pkg::FifoDepth))
    else $error("result queue overfilled");

  // a line status is always the final result of its beat
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == cals_pkg::KIND_ACCEPT ||
                      m_axis_tuser == cals_pkg::KIND_REJECT) |-> m_axis_tlast)
    else $error("line status without tlast");

  // a line close returns the parser to its idle state
  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && s_axis_tlast |=> (quote_q == cals_pkg::QUOTE_NONE) && !in_arg_q &&
                                !esc_q && (count_q == 8'd0))
    else $error("parser not cleared after line close");

  // every accepted beat finds room for all of its results
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> fill_q + cals_pkg::CntW'(n_res) <= cals_pkg::CntW'(cals_pkg::FifoDepth))
    else $error("push beyond queue room");

endmodule

`default_nettype wire
